[src/assert_macros.svh]
// Assertion macros for the RTL files; merge_sorter.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLKRST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, during reset too.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/mrgs_pkg.sv]
// Package with types and constants for the merge sorter.
`default_nettype none

package mrgs_pkg;

    localparam int MAX_COUNT = 64;
    localparam int IDX_W     = $clog2(MAX_COUNT);
    localparam int CNT_W     = IDX_W + 1;
    localparam int SUM_W     = CNT_W + 1;
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     sample_last;
    } sample_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     sorted_last;
    } sorted_item_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

[src/merge_sorter.sv]
// Merge sorter: loads a list, sorts it by bottom-up merge passes, streams it out.
// Load: one item per cycle; the list ends on an item marked last (items past 64 dropped).
// Sort: merge passes, run width doubled each pass, one element per cycle per merge pass.
// Output: first result the cycle after sorting ends, then one per cycle while sorted_ready.
// The rate is set by the merge loop reading both run heads from one memory each cycle.
// Reset clears the state and the loaded count; the two memories are not cleared.
`default_nettype none

module merge_sorter (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_ready,
    input  wire mrgs_pkg::sample_item_t sample,
    output logic                       sorted_valid,
    input  wire logic                  sorted_ready,
    output mrgs_pkg::sorted_item_t     sorted
);

    localparam int IDX_W  = mrgs_pkg::IDX_W;
    localparam int CNT_W  = mrgs_pkg::CNT_W;
    localparam int SUM_W  = mrgs_pkg::SUM_W;
    localparam int DATA_W = mrgs_pkg::DATA_W;

    mrgs_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] l_reg, l_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic             src_sel_reg, src_sel_next;

    logic [DATA_W-1:0] prim_mem [mrgs_pkg::MAX_COUNT];
    logic [DATA_W-1:0] scr_mem  [mrgs_pkg::MAX_COUNT];
    logic [DATA_W-1:0] prim_rd_l_reg, prim_rd_r_reg;
    logic [DATA_W-1:0] scr_rd_l_reg, scr_rd_r_reg;

    logic              prim_we, scr_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    logic              in_fire, out_fire;
    logic              sort_done, out_last;
    logic              take_l;
    logic signed [DATA_W-1:0] head_l, head_r;
    logic [SUM_W-1:0]  base, run_w, mid_c, hi_c, width2, n_ext;

    assign in_fire  = sample_valid && sample_ready;
    assign out_fire = sorted_valid && sorted_ready;

    // Registered read data of the memory that holds the current source runs.
    assign head_l = $signed(src_sel_reg ? scr_rd_l_reg : prim_rd_l_reg);
    assign head_r = $signed(src_sel_reg ? scr_rd_r_reg : prim_rd_r_reg);

    assign out_last = ((l_reg + CNT_W'(1)) == count_reg);
    assign take_l   = (l_reg < mid_reg) && (!(r_reg < hi_reg) || (head_l <= head_r));
    assign n_ext    = {1'b0, count_reg};

    // Datapath and loop control.
    always_comb
    begin
        l_next       = l_reg;
        r_next       = r_reg;
        k_next       = k_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        width_next   = width_reg;
        src_sel_next = src_sel_reg;
        count_next   = count_reg;
        prim_we      = 1'b0;
        scr_we       = 1'b0;
        wr_addr      = k_reg[IDX_W-1:0];
        wr_data      = take_l ? head_l : head_r;
        sort_done    = 1'b0;
        base         = '0;
        run_w        = '0;
        mid_c        = '0;
        hi_c         = '0;
        width2       = {1'b0, width_reg} << 1;
        case (state_reg)
            mrgs_pkg::ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (count_reg < CNT_W'(mrgs_pkg::MAX_COUNT))
                    begin
                        prim_we    = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        wr_data    = sample.sample_value;
                        count_next = count_reg + CNT_W'(1);
                    end
                    // Set up the first pass: runs of one element.
                    l_next       = '0;
                    r_next       = CNT_W'(1);
                    k_next       = '0;
                    mid_next     = CNT_W'(1);
                    hi_next      = (count_next >= CNT_W'(2)) ? CNT_W'(2) : count_next;
                    width_next   = CNT_W'(1);
                    src_sel_next = 1'b0;
                end
            end
            mrgs_pkg::ST_SORT:
            begin
                prim_we = src_sel_reg;
                scr_we  = !src_sel_reg;
                if ((k_reg + CNT_W'(1)) == hi_reg)
                begin
                    if (hi_reg == count_reg)
                    begin
                        // End of a pass: the destination becomes the source.
                        src_sel_next = !src_sel_reg;
                        if (width2 >= n_ext)
                        begin
                            sort_done = 1'b1;
                            l_next    = '0;
                        end
                        else
                        begin
                            base       = '0;
                            run_w      = width2;
                            width_next = width2[CNT_W-1:0];
                        end
                    end
                    else
                    begin
                        base  = {1'b0, hi_reg};
                        run_w = {1'b0, width_reg};
                    end
                    if (!sort_done)
                    begin
                        mid_c    = base + run_w;
                        hi_c     = base + (run_w << 1);
                        mid_c    = (mid_c > n_ext) ? n_ext : mid_c;
                        hi_c     = (hi_c > n_ext) ? n_ext : hi_c;
                        l_next   = base[CNT_W-1:0];
                        k_next   = base[CNT_W-1:0];
                        r_next   = mid_c[CNT_W-1:0];
                        mid_next = mid_c[CNT_W-1:0];
                        hi_next  = hi_c[CNT_W-1:0];
                    end
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                    if (take_l)
                        l_next = l_reg + CNT_W'(1);
                    else
                        r_next = r_reg + CNT_W'(1);
                end
            end
            mrgs_pkg::ST_OUT:
            begin
                if (out_fire)
                begin
                    if (out_last)
                        count_next = '0;
                    else
                        l_next = l_reg + CNT_W'(1);
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrgs_pkg::ST_LOAD:
            begin
                if (in_fire && sample.sample_last)
                begin
                    if (count_next == CNT_W'(1))
                        state_next = mrgs_pkg::ST_OUT;
                    else
                        state_next = mrgs_pkg::ST_SORT;
                end
            end
            mrgs_pkg::ST_SORT:
            begin
                if (sort_done)
                    state_next = mrgs_pkg::ST_OUT;
            end
            mrgs_pkg::ST_OUT:
            begin
                if (out_fire && out_last)
                    state_next = mrgs_pkg::ST_LOAD;
            end
            default:
            begin
                state_next = mrgs_pkg::ST_LOAD;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        sample_ready = 1'b0;
        sorted_valid = 1'b0;
        case (state_reg)
            mrgs_pkg::ST_LOAD: sample_ready = 1'b1;
            mrgs_pkg::ST_OUT:  sorted_valid = 1'b1;
            default:
            begin
                sample_ready = 1'b0;
                sorted_valid = 1'b0;
            end
        endcase
    end

    assign sorted.sorted_value = head_l;
    assign sorted.sorted_last  = out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mrgs_pkg::ST_LOAD;
            count_reg   <= '0;
            l_reg       <= '0;
            r_reg       <= '0;
            k_reg       <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            width_reg   <= '0;
            src_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            l_reg       <= l_next;
            r_reg       <= r_next;
            k_reg       <= k_next;
            mid_reg     <= mid_next;
            hi_reg      <= hi_next;
            width_reg   <= width_next;
            src_sel_reg <= src_sel_next;
        end
    end

    // Both memories read at the next run heads; a write to the same entry is forwarded.
    always_ff @(posedge clk)
    begin
        if (prim_we)
            prim_mem[wr_addr] <= wr_data;
        prim_rd_l_reg <= (prim_we && (wr_addr == l_next[IDX_W-1:0]))
                         ? wr_data : prim_mem[l_next[IDX_W-1:0]];
        prim_rd_r_reg <= (prim_we && (wr_addr == r_next[IDX_W-1:0]))
                         ? wr_data : prim_mem[r_next[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scr_mem[wr_addr] <= wr_data;
        scr_rd_l_reg <= (scr_we && (wr_addr == l_next[IDX_W-1:0]))
                        ? wr_data : scr_mem[l_next[IDX_W-1:0]];
        scr_rd_r_reg <= (scr_we && (wr_addr == r_next[IDX_W-1:0]))
                        ? wr_data : scr_mem[r_next[IDX_W-1:0]];
    end

`include "assert_macros.svh"

    `ASSERT_CLK(a_no_overlap, !(sample_ready && sorted_valid), "input and output both open")
    `ASSERT_CLKRST(a_count_max, count_reg <= CNT_W'(mrgs_pkg::MAX_COUNT), "count too large")
    `ASSERT_CLKRST(a_run_write, (state_reg == mrgs_pkg::ST_SORT) |-> ((k_reg < hi_reg) && (l_reg <= mid_reg) && (mid_reg <= hi_reg)), "merge indexes out of run")
    `ASSERT_CLKRST(a_out_index, (state_reg == mrgs_pkg::ST_OUT) |-> (l_reg < count_reg), "output index past list")
    `ASSERT_CLKRST(a_back_to_load, (out_fire && sorted.sorted_last) |=> (sample_ready && (count_reg == '0)), "list not restarted")

endmodule

`default_nettype wire
